### rtl/core/fpmso_pkg.sv
`timescale 1ns / 1ps
// Package for the feedback phase-modulation sine oscillator.
// Holds sizes, register indexes, the configuration struct and constant tables; no dependencies.

package fpmso_pkg;

    // Sizes of the datapath.
    localparam int PHASE_BITS      = 32;
    localparam int SAMPLE_BITS     = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);
    localparam int PITCH_W         = 16;
    localparam int ANGLE_W         = 32;
    localparam int MUL_W           = 33;
    localparam int PROD_W          = 64;
    localparam int EXP_W           = 22;
    localparam int OCT_N_W         = 6;
    localparam int CENT_Q_W        = 14;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OCTAVE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FEEDBACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HARMONIC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOD_DEPTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE_STEP = 3'd6;

    localparam logic [15:0] HARMONIC_RST  = 16'd8192;
    localparam logic [30:0] BASE_STEP_RST = 31'd23411420;

    typedef struct packed {
        logic              enable;
        logic signed [3:0] octave_offset;
        logic signed [7:0] cent_offset;
        logic [15:0]       feedback_gain;
        logic [15:0]       harmonic_ratio;
        logic [15:0]       inner_mod_depth;
        logic [30:0]       base_step;
    } t_cfg;

    // Arithmetic constants.
    localparam int SHIFT_BASE = 62 - PHASE_BITS;
    localparam int FB_FRAC    = SAMPLE_BITS + 13;
    localparam int OUT_SHIFT  = 31 - SAMPLE_BITS;
    localparam int CENT_DIV   = 1200;
    localparam int CENT_HALF  = 600;

    localparam logic [62:0]        NYQ_STEP   = 63'(1) << (PHASE_BITS - 1);
    localparam logic [31:0]        ANGLE_PI   = 32'h8000_0000;
    localparam logic [30:0]        SIN_ONE    = 31'h4000_0000;
    localparam logic [32:0]        DIV5_MAGIC = 33'h0_CCCC_CCCD;
    localparam logic signed [31:0] OUT_ROUND  = 32'(1) << (OUT_SHIFT - 1);
    localparam logic signed [31:0] OUT_MAX    = 32'((1 << (SAMPLE_BITS - 1)) - 1);

    // Bitwise integer square root, 32 result bits.
    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = v;
        root = 64'd0;
        b    = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // 2^(i/D) in Q2.30, built from products of truncated roots of two.
    typedef logic [31:0] t_exp_tab [0:EXP_TABLE_DEPTH];

    function automatic t_exp_tab f_exp_tab();
        t_exp_tab    tab;
        logic [63:0] roots [1:16];
        logic [63:0] f;
        logic [63:0] r;
        roots[1] = f_isqrt(64'd1 << 61);
        for (int k = 2; k <= 16; k++) begin
            roots[k] = f_isqrt(roots[k-1] << 30);
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            f = (64'(i) << 16) / EXP_TABLE_DEPTH;
            r = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (f[16-k]) begin
                    r = (r * roots[k]) >> 30;
                end
            end
            tab[i] = r[31:0];
        end
        tab[EXP_TABLE_DEPTH] = 32'h8000_0000;
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_exp_tab();

    // Cents as a Q.16 fraction of an octave, rounded half away from zero.
    typedef logic [CENT_Q_W-1:0] t_cent_tab [0:255];

    function automatic t_cent_tab f_cent_tab();
        t_cent_tab tab;
        for (int m = 0; m < 256; m++) begin
            tab[m] = CENT_Q_W'((m * 65536 + CENT_HALF) / CENT_DIV);
        end
        return tab;
    endfunction

    localparam t_cent_tab CENT_TAB = f_cent_tab();

endpackage

### rtl/core/fpmso_pitch_if.sv
`timescale 1ns / 1ps
// Channel carrying pitch samples into the oscillator.
// Depends on fpmso_pkg for the field width.

interface fpmso_pitch_if import fpmso_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PITCH_W-1:0] pitch_volts;

    modport source (output valid, output pitch_volts, input ready);
    modport sink   (input valid, input pitch_volts, output ready);
endinterface

### rtl/core/fpmso_audio_if.sv
`timescale 1ns / 1ps
// Channel carrying audio samples out of the oscillator.
// Depends on fpmso_pkg for the sample width.

interface fpmso_audio_if import fpmso_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] audio_out;

    modport source (output valid, output audio_out, input ready);
    modport sink   (input valid, input audio_out, output ready);
endinterface

### rtl/core/fpmso_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank of the oscillator.
// Depends on fpmso_pkg for register indexes, reset values and t_cfg.

module fpmso_cfg import fpmso_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                CFG_IDX_ENABLE:    n_cfg.enable          = i_data[0];
                CFG_IDX_OCTAVE:    n_cfg.octave_offset   = i_data[3:0];
                CFG_IDX_CENT:      n_cfg.cent_offset     = i_data[7:0];
                CFG_IDX_FEEDBACK:  n_cfg.feedback_gain   = i_data[15:0];
                CFG_IDX_HARMONIC:  n_cfg.harmonic_ratio  = i_data[15:0];
                CFG_IDX_MOD_DEPTH: n_cfg.inner_mod_depth = i_data[15:0];
                CFG_IDX_BASE_STEP: n_cfg.base_step       = i_data[30:0];
                default:           n_cfg                 = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b0;
            r_cfg.octave_offset   <= 4'sd0;
            r_cfg.cent_offset     <= 8'sd0;
            r_cfg.feedback_gain   <= 16'd0;
            r_cfg.harmonic_ratio  <= HARMONIC_RST;
            r_cfg.inner_mod_depth <= 16'd0;
            r_cfg.base_step       <= BASE_STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/fpmso_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on fpmso_pkg for operand and product widths.

module fpmso_mul import fpmso_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [MUL_W-1:0] i_a,
    input  logic signed [MUL_W-1:0] i_b,
    output logic [PROD_W-1:0]       o_prod
);

    logic signed [2*MUL_W-1:0] full;
    logic [PROD_W-1:0]         r_prod;

    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/fpmso_seq.sv
`timescale 1ns / 1ps
// Sequencer and datapath of the oscillator: drives the shared multiplier through
// the pitch-to-step, inner sine, feedback and outer sine steps. Depends on fpmso_pkg.

module fpmso_seq import fpmso_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    fpmso_pitch_if.sink             i_pitch,
    fpmso_audio_if.source           o_audio,
    output logic signed [MUL_W-1:0] o_mul_a,
    output logic signed [MUL_W-1:0] o_mul_b,
    input  logic [PROD_W-1:0]       i_prod
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_X1   = 4'd1;
    localparam logic [3:0] ST_X2   = 4'd2;
    localparam logic [3:0] ST_HR   = 4'd3;
    localparam logic [3:0] ST_A0   = 4'd4;
    localparam logic [3:0] ST_P1   = 4'd5;
    localparam logic [3:0] ST_P2   = 4'd6;
    localparam logic [3:0] ST_P3   = 4'd7;
    localparam logic [3:0] ST_P4   = 4'd8;
    localparam logic [3:0] ST_MD   = 4'd9;
    localparam logic [3:0] ST_FB   = 4'd10;
    localparam logic [3:0] ST_A1   = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    // Control state.
    logic [3:0]                    r_state, n_state;
    logic                          r_pass, n_pass;
    logic                          r_out_valid, n_out_valid;
    logic [PHASE_BITS-1:0]         r_phase, n_phase;
    logic signed [SAMPLE_BITS-1:0] r_last, n_last;

    // Working registers.
    logic [SAMPLE_BITS-1:0]   r_out_data, n_out_data;
    logic [SAMPLE_BITS-1:0]   r_res, n_res;
    logic [31:0]              r_tab_lo, n_tab_lo;
    logic [31:0]              r_tab_hi, n_tab_hi;
    logic [15:0]              r_w, n_w;
    logic signed [OCT_N_W-1:0] r_n, n_n;
    logic [PHASE_BITS-1:0]    r_step, n_step;
    logic [ANGLE_W-1:0]       r_angle, n_angle;
    logic [30:0]              r_p, n_p;
    logic signed [31:0]       r_sin, n_sin;
    logic [ANGLE_W-1:0]       r_arg, n_arg;

    logic accept;

    // Pitch to exponent and table lookup.
    logic [7:0]              cent_mag;
    logic [CENT_Q_W-1:0]     cent_q;
    logic [EXP_W-1:0]        cent_term;
    logic [EXP_W-1:0]        exp_e;
    logic [EXP_IDX_BITS-1:0] exp_idx;
    logic [EXP_IDX_BITS:0]   exp_idx_nx;
    logic [15:0]             exp_w;

    // Step scaling.
    logic [PHASE_BITS+ANGLE_W-1:0] ph_ext;
    logic [ANGLE_W-1:0]            ph_turn;
    logic [7:0]                    sh_full;
    logic [62:0]                   step_shr;
    logic [PHASE_BITS-1:0]         step_sat;
    logic [31:0]                   ratio;

    // Sine evaluation.
    logic [31:0]        m_abs;
    logic [31:0]        m_cmp;
    logic [30:0]        p_val;
    logic [30:0]        p_cmp;
    logic [28:0]        q_val;
    logic [31:0]        q9;
    logic [28:0]        y_val;
    logic [29:0]        d_val;
    logic [30:0]        g_val;
    logic signed [31:0] sin_val;

    // Angle sums and output rounding.
    logic [ANGLE_W-1:0]         t_inner;
    logic [PROD_W+30:0]         fb_ext;
    logic [ANGLE_W-1:0]         t_fb;
    logic signed [31:0]         rnd_sum;
    logic signed [31:0]         rnd_shr;
    logic [SAMPLE_BITS-1:0]     res_val;

    assign accept = i_pitch.valid && (r_state == ST_IDLE);

    assign cent_mag  = i_cfg.cent_offset[7] ? (8'd0 - i_cfg.cent_offset) : i_cfg.cent_offset;
    assign cent_q    = CENT_TAB[cent_mag];
    assign cent_term = i_cfg.cent_offset[7] ? (EXP_W'(0) - EXP_W'(cent_q)) : EXP_W'(cent_q);
    assign exp_e     = {{2{i_pitch.pitch_volts[PITCH_W-1]}}, i_pitch.pitch_volts, 4'b0}
                     + {{2{i_cfg.octave_offset[3]}}, i_cfg.octave_offset, 16'b0}
                     + cent_term;
    assign exp_idx    = exp_e[15 -: EXP_IDX_BITS];
    assign exp_idx_nx = {1'b0, exp_idx} + 1'b1;
    assign exp_w      = exp_e[15:0] << EXP_IDX_BITS;

    assign ph_ext   = {r_phase, 32'b0};
    assign ph_turn  = ph_ext[PHASE_BITS+31 -: ANGLE_W];
    assign sh_full  = 8'(SHIFT_BASE) - {{2{r_n[OCT_N_W-1]}}, r_n};
    assign step_shr = i_prod[62:0] >> sh_full[6:0];
    assign step_sat = (step_shr > NYQ_STEP) ? NYQ_STEP[PHASE_BITS-1:0]
                                            : step_shr[PHASE_BITS-1:0];
    assign ratio    = r_tab_lo + i_prod[47:16];

    assign m_abs   = r_angle[31] ? (32'd0 - r_angle) : r_angle;
    assign m_cmp   = ANGLE_PI - m_abs;
    assign p_val   = i_prod[60:30];
    assign p_cmp   = SIN_ONE - p_val;
    assign q_val   = i_prod[58:30];
    assign q9      = {3'b0, q_val} + {q_val, 3'b0};
    assign y_val   = q9[31:3];
    assign d_val   = i_prod[63:34];
    assign g_val   = r_p - {1'b0, d_val};
    assign sin_val = r_angle[31] ? (32'sd0 - $signed({1'b0, g_val})) : $signed({1'b0, g_val});

    assign t_inner = i_prod[44:13];
    assign fb_ext  = {i_prod, 31'b0};
    assign t_fb    = fb_ext[FB_FRAC+31 -: ANGLE_W];

    assign rnd_sum = r_sin + OUT_ROUND;
    assign rnd_shr = rnd_sum >>> OUT_SHIFT;
    assign res_val = (rnd_shr > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-1:0] : rnd_shr[SAMPLE_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_out_valid = r_out_valid;
        n_phase     = r_phase;
        n_last      = r_last;
        n_out_data  = r_out_data;
        n_res       = r_res;
        n_tab_lo    = r_tab_lo;
        n_tab_hi    = r_tab_hi;
        n_w         = r_w;
        n_n         = r_n;
        n_step      = r_step;
        n_angle     = r_angle;
        n_p         = r_p;
        n_sin       = r_sin;
        n_arg       = r_arg;
        o_mul_a     = '0;
        o_mul_b     = '0;

        if (r_out_valid && o_audio.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_tab_lo = EXP_TAB[exp_idx];
                    n_tab_hi = EXP_TAB[exp_idx_nx];
                    n_w      = exp_w;
                    n_n      = exp_e[EXP_W-1:16];
                    n_res    = '0;
                    n_state  = i_cfg.enable ? ST_X1 : ST_DONE;
                end
            end
            ST_X1: begin
                // Interpolation weight times the table slope.
                o_mul_a = {1'b0, r_tab_hi - r_tab_lo};
                o_mul_b = {17'b0, r_w};
                n_state = ST_X2;
            end
            ST_X2: begin
                o_mul_a = {2'b0, i_cfg.base_step};
                o_mul_b = {1'b0, ratio};
                n_state = ST_HR;
            end
            ST_HR: begin
                n_step  = step_sat;
                o_mul_a = {ph_turn[ANGLE_W-1], ph_turn};
                o_mul_b = {17'b0, i_cfg.harmonic_ratio};
                n_state = ST_A0;
            end
            ST_A0: begin
                n_angle = i_prod[43:12];
                n_pass  = 1'b0;
                n_state = ST_P1;
            end
            ST_P1: begin
                o_mul_a = {1'b0, m_abs};
                o_mul_b = {1'b0, m_cmp};
                n_state = ST_P2;
            end
            ST_P2: begin
                n_p     = p_val;
                o_mul_a = {2'b0, p_val};
                o_mul_b = {2'b0, p_cmp};
                n_state = ST_P3;
            end
            ST_P3: begin
                // Division by 40 as a shift by three and a reciprocal multiply by five.
                o_mul_a = {4'b0, y_val};
                o_mul_b = DIV5_MAGIC;
                n_state = ST_P4;
            end
            ST_P4: begin
                n_sin   = sin_val;
                n_state = r_pass ? ST_FIN : ST_MD;
            end
            ST_MD: begin
                o_mul_a = {17'b0, i_cfg.inner_mod_depth};
                o_mul_b = {r_sin[31], r_sin};
                n_state = ST_FB;
            end
            ST_FB: begin
                n_arg   = ph_turn + t_inner;
                o_mul_a = {17'b0, i_cfg.feedback_gain};
                o_mul_b = {{(MUL_W-SAMPLE_BITS){r_last[SAMPLE_BITS-1]}}, r_last};
                n_state = ST_A1;
            end
            ST_A1: begin
                n_angle = r_arg + t_fb;
                n_pass  = 1'b1;
                n_state = ST_P1;
            end
            ST_FIN: begin
                n_res   = res_val;
                n_last  = res_val;
                n_phase = r_phase + r_step;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_audio.ready) begin
                    n_out_data  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_res      <= n_res;
        r_tab_lo   <= n_tab_lo;
        r_tab_hi   <= n_tab_hi;
        r_w        <= n_w;
        r_n        <= n_n;
        r_step     <= n_step;
        r_angle    <= n_angle;
        r_p        <= n_p;
        r_sin      <= n_sin;
        r_arg      <= n_arg;
    end

    assign i_pitch.ready     = (r_state == ST_IDLE);
    assign o_audio.valid     = r_out_valid;
    assign o_audio.audio_out = r_out_data;

endmodule

### rtl/core/feedback_pm_sine_oscillator.sv
`timescale 1ns / 1ps
// Top level of the feedback phase-modulation sine oscillator.
// Depends on fpmso_pkg, the two channel interfaces, fpmso_cfg, fpmso_mul and fpmso_seq.
//
//   Channel     Direction  Payload               Meaning
//   i_pitch_ch  in         pitch_volts  s16      pitch, Q4.12 volts per octave, 0 V is middle C
//   o_audio_ch  out        audio_out    s16      oscillator sample, Q1.15
//   i_cfg_*     in         3-bit index, 31 bits  register writes, no read-back
//
// An enabled sample occupies the block from its transfer through the two sine passes until
// its result is handed on; the next pitch is taken only once the block is idle again,
// so one sample is in work at a time. The pace is set by the eleven products that share
// one multiplier. A sample taken while disabled skips the computation and returns zero.
// Reset is synchronous and active low; it clears the phase, the fed-back sample and
// the registers to their defaults. A stalled output holds its sample in the output
// register while the next pitch is already accepted and computed.

module feedback_pm_sine_oscillator import fpmso_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fpmso_pitch_if.sink           i_pitch_ch,
    fpmso_audio_if.source         o_audio_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The register bank gives the sequencer a steady set of controls; they are only to be
    // written between samples, which the block does not enforce, so the sequencer reads them directly.
    t_cfg cfg;

    // Operands and registered product of the shared multiplier. Every product is
    // registered before it feeds the next step.
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic [PROD_W-1:0]       mul_prod;

    fpmso_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    fpmso_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // The sequencer turns the pitch into a phase step through the exponent table and
    // interpolation, then evaluates the inner sine of the scaled phase, adds the inner
    // modulation and the fed-back sample to the phase, and evaluates the outer sine.
    // The phase advances only after the sample has been formed from the old phase.
    fpmso_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pitch (i_pitch_ch),
        .o_audio (o_audio_ch),
        .o_mul_a (mul_a),
        .o_mul_b (mul_b),
        .i_prod  (mul_prod)
    );

    // A pitch transfer always starts a busy period.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pitch_ch.valid && i_pitch_ch.ready) |=> !i_pitch_ch.ready)
        else $error("input still ready in the cycle after a pitch transfer");

    // A new sample appears only from the busy state, never while idle.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_audio_ch.valid) |-> !$past(i_pitch_ch.ready))
        else $error("output sample appeared while the block was idle");

    // The block leaves the idle state only on a pitch transfer.
    a_busy_needs_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_pitch_ch.ready) |-> $past(i_pitch_ch.valid))
        else $error("input ready dropped without a pitch transfer");

endmodule

### tb/sv/fpmso_sample_checker.sv
`timescale 1ns / 1ps
// Checker for the feedback phase-modulation sine oscillator: watches both channels and the
// register port, predicts every audio sample and compares it. Depends on fpmso_pkg and the
// two channel interfaces.

module fpmso_sample_checker import fpmso_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fpmso_pitch_if                i_pitch_mon,
    fpmso_audio_if                i_audio_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatch_count,
    output int                    o_pending
);

    // Shadow copy of the registers.
    logic              run_enable;
    logic signed [3:0] octave_shift;
    logic signed [7:0] cent_detune;
    logic [15:0]       fb_gain;
    logic [15:0]       harm_ratio;
    logic [15:0]       mod_depth;
    logic [30:0]       base_step;

    // Oscillator state as the block should hold it.
    logic [PHASE_BITS-1:0]         phase_acc;
    logic signed [SAMPLE_BITS-1:0] last_out;

    longint unsigned        exp2_frac [0:EXP_TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] expected_audio [$];
    int                     mismatch_count = 0;

    function automatic longint unsigned isqrt_u64(input longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Table of 2^(i/D) in Q2.30, each entry a product of truncated roots of two.
    initial begin : build_exp2
        longint unsigned roots [1:16];
        longint unsigned r;
        int              f;
        roots[1] = isqrt_u64(64'd1 << 61);
        for (int k = 2; k <= 16; k++) begin
            roots[k] = isqrt_u64(roots[k-1] << 30);
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            f = (i << 16) / EXP_TABLE_DEPTH;
            r = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (((f >> (16 - k)) & 1) != 0) begin
                    r = (r * roots[k]) >> 30;
                end
            end
            exp2_frac[i] = {32'd0, r[31:0]};
        end
        exp2_frac[EXP_TABLE_DEPTH] = 64'd1 << 31;
    end

    // Parabolic sine of a turn angle (Q1.31 of angle/pi), result in Q30, odd in the angle.
    function automatic longint parabolic_sine(input logic [31:0] ang);
        logic [31:0]     neg;
        longint unsigned mag;
        longint unsigned par;
        longint unsigned corr;
        longint unsigned g;
        neg  = -ang;
        mag  = {32'd0, (ang[31] ? neg : ang)};
        par  = (mag * ((64'd1 << 31) - mag)) >> 30;
        corr = (((par * ((64'd1 << 30) - par)) >> 30) * 64'd9) / 64'd40;
        g    = par - corr;
        return ang[31] ? -$signed(g) : $signed(g);
    endfunction

    // Phase increment for one pitch sample, saturated at Nyquist.
    function automatic logic [PHASE_BITS-1:0] pitch_to_increment(
        input logic signed [PITCH_W-1:0] pitch
    );
        int              cent_mag;
        int              cent_q;
        int              expo;
        int              oct_n;
        int              sh;
        int              ti;
        logic [15:0]     frac;
        longint unsigned wgt;
        longint unsigned ratio;
        longint unsigned prod;
        longint unsigned st;
        longint unsigned nyq;
        nyq      = 64'd1 << (PHASE_BITS - 1);
        cent_mag = (cent_detune < 0) ? -int'(cent_detune) : int'(cent_detune);
        cent_q   = (cent_mag * 65536 + 600) / 1200;
        expo     = int'(pitch) * 16 + int'(octave_shift) * 65536
                 + ((cent_detune < 0) ? -cent_q : cent_q);
        oct_n    = expo >>> 16;
        frac     = expo[15:0];
        ti       = int'(frac[15:8]);
        wgt      = {48'd0, frac[7:0], 8'd0};
        ratio    = exp2_frac[ti] + (((exp2_frac[ti+1] - exp2_frac[ti]) * wgt) >> 16);
        prod     = {33'd0, base_step} * ratio;
        sh       = oct_n - SHIFT_BASE;
        if (sh >= 0) begin
            if (sh >= 63 || prod > (nyq >> sh)) begin
                st = nyq;
            end else begin
                st = prod << sh;
            end
        end else begin
            st = (sh <= -64) ? 64'd0 : (prod >> (-sh));
        end
        if (st > nyq) begin
            st = nyq;
        end
        return st[PHASE_BITS-1:0];
    endfunction

    // One audio sample; advances the shadow phase and fed-back sample when enabled.
    function automatic logic [SAMPLE_BITS-1:0] predict_audio(
        input logic signed [PITCH_W-1:0] pitch
    );
        logic [31:0] ang;
        logic [31:0] inner_term;
        logic [31:0] fb_term;
        logic [31:0] arg;
        longint      harm_prod;
        longint      inner_prod;
        longint      fb_prod;
        longint      rounded;
        if (!run_enable) begin
            return '0;
        end
        ang        = phase_acc;
        harm_prod  = longint'($signed(ang)) * longint'(harm_ratio);
        inner_prod = longint'(mod_depth) * parabolic_sine(harm_prod[43:12]);
        inner_term = inner_prod[44:13];
        fb_prod    = longint'(fb_gain) * longint'(last_out);
        fb_term    = {fb_prod[29:0], 2'b00};
        arg        = ang + inner_term + fb_term;
        rounded    = (parabolic_sine(arg) + 64'sd16384) >>> OUT_SHIFT;
        if (rounded > 64'sd32767) begin
            rounded = 64'sd32767;
        end
        last_out  = rounded[SAMPLE_BITS-1:0];
        phase_acc = phase_acc + pitch_to_increment(pitch);
        return last_out;
    endfunction

    always @(posedge i_clk) begin : track
        logic [SAMPLE_BITS-1:0] want;
        if (!i_rst_n) begin
            run_enable   = 1'b0;
            octave_shift = '0;
            cent_detune  = '0;
            fb_gain      = '0;
            harm_ratio   = HARMONIC_RST;
            mod_depth    = '0;
            base_step    = BASE_STEP_RST;
            phase_acc    = '0;
            last_out     = '0;
            expected_audio.delete();
        end else begin
            if (i_audio_mon.valid && i_audio_mon.ready) begin
                if (expected_audio.size() == 0) begin
                    $display("%0t: audio_out expected none, got %0d", $time,
                             $signed(i_audio_mon.audio_out));
                    mismatch_count++;
                end else begin
                    want = expected_audio.pop_front();
                    if (i_audio_mon.audio_out !== want) begin
                        $display("%0t: audio_out expected %0d, got %0d", $time,
                                 $signed(want), $signed(i_audio_mon.audio_out));
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_ENABLE:    run_enable   = i_cfg_data[0];
                    CFG_IDX_OCTAVE:    octave_shift = i_cfg_data[3:0];
                    CFG_IDX_CENT:      cent_detune  = i_cfg_data[7:0];
                    CFG_IDX_FEEDBACK:  fb_gain      = i_cfg_data[15:0];
                    CFG_IDX_HARMONIC:  harm_ratio   = i_cfg_data[15:0];
                    CFG_IDX_MOD_DEPTH: mod_depth    = i_cfg_data[15:0];
                    CFG_IDX_BASE_STEP: base_step    = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_pitch_mon.valid && i_pitch_mon.ready) begin
                expected_audio.push_back(predict_audio(i_pitch_mon.pitch_volts));
            end
        end
        o_mismatch_count <= mismatch_count;
        o_pending        <= expected_audio.size();
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the oscillator testbench: clock, reset, pitch stimulus, audio back-pressure and verdict.
// Depends on fpmso_pkg, the channel interfaces, the oscillator RTL and fpmso_sample_checker.

module tb_top;
    import fpmso_pkg::*;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    localparam int RANDOM_PITCHES  = 1700;
    // Cycles without any transfer before the run is declared hung. The slowest legal gap is
    // the long output hold-off plus one sample time, so this leaves a wide margin.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    // After the last sample, wait this long for anything unexpected.
    localparam int TAIL_CYCLES     = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Random idling on both channels is allowed while this is set.
    logic jitter_on;
    // Each increment asks the audio receiver for one long hold-off.
    int   hold_asks;
    int   mismatch_count;
    int   samples_pending;

    fpmso_pitch_if pitch_ch ();
    fpmso_audio_if audio_ch ();

    always #1 i_clk = ~i_clk;

    feedback_pm_sine_oscillator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pitch_ch (pitch_ch),
        .o_audio_ch (audio_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fpmso_sample_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pitch_mon      (pitch_ch),
        .i_audio_mon      (audio_ch),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (samples_pending)
    );

    // One register write. The bits above the register's width carry random junk, which the
    // block has to ignore.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] mask;
        junk = CFG_DATA_W'($urandom);
        mask = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((64'd1 << width) - 64'd1);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= (junk & ~mask) | (CFG_DATA_W'(value) & mask);
        @(posedge i_clk);
    endtask

    // Writes every register, plus one write to the unused index, then releases the port.
    task automatic apply_config(input logic run, input int octave, input int cents,
                                input int fb, input int ratio, input int depth, input int base);
        write_reg(CFG_IDX_BASE_STEP, base, 31);
        write_reg(CFG_IDX_OCTAVE, octave, 4);
        write_reg(CFG_IDX_CENT, cents, 8);
        write_reg(CFG_IDX_FEEDBACK, fb, 16);
        write_reg(CFG_IDX_SPARE, $urandom, 31);
        write_reg(CFG_IDX_HARMONIC, ratio, 16);
        write_reg(CFG_IDX_MOD_DEPTH, depth, 16);
        write_reg(CFG_IDX_ENABLE, run, 1);
        cfg_we <= 1'b0;
    endtask

    // Offers one pitch sample and returns at the edge where the transfer takes place. The
    // valid line stays high afterwards so that back-to-back samples leave no gap.
    task automatic send_pitch(input logic [PITCH_W-1:0] volts);
        if (jitter_on && $urandom_range(0, 2) == 0) begin
            pitch_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        pitch_ch.valid       <= 1'b1;
        pitch_ch.pitch_volts <= volts;
        do @(posedge i_clk); while (!pitch_ch.ready);
    endtask

    // Stops offering and waits until every predicted sample has come out. The checker's count
    // is registered, hence the task always waits on the clock before it first looks at it.
    task automatic drain_samples();
        pitch_ch.valid <= 1'b0;
        do @(posedge i_clk); while (samples_pending != 0);
    endtask

    // Gains and ratios: the extremes, the musically useful lower quarter, or anything.
    function automatic int pick_gain();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(0, 16384);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_base();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 32'h7FFF_FFFF);
            3, 4:    return BASE_STEP_RST;
            default: return $urandom_range(1, 1 << 27);
        endcase
    endfunction

    // Mostly notes within four octaves of middle C, some held notes and some wild values.
    function automatic logic [PITCH_W-1:0] pick_pitch(input logic [PITCH_W-1:0] prev);
        case ($urandom_range(0, 9))
            0:       return prev;
            1, 2:    return PITCH_W'($urandom);
            default: return PITCH_W'($urandom_range(0, 32767) - 16384);
        endcase
    endfunction

    // The audio receiver. It stalls in random bursts while idling is allowed, and honours a
    // long hold-off whenever one is asked for, counting the cycles itself. Each pass of the
    // loop drives ready once and then lets the chosen number of edges go by.
    initial begin : audio_receiver
        int hold_seen;
        int span;
        hold_seen = 0;
        audio_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                audio_ch.ready <= 1'b0;
                span = HOLD_OFF_CYCLES;
            end else if (jitter_on && $urandom_range(0, 7) == 0) begin
                audio_ch.ready <= 1'b0;
                span = $urandom_range(1, 17);
            end else begin
                audio_ch.ready <= 1'b1;
                span = 1;
            end
            repeat (span) @(posedge i_clk);
        end
    end

    // Ends the run if neither channel has moved a transfer for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pitch_ch.valid && pitch_ch.ready) || (audio_ch.valid && audio_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        logic [PITCH_W-1:0] volts;
        int                 done;
        int                 batch;
        int                 phase_no;

        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        pitch_ch.valid       <= 1'b0;
        pitch_ch.pitch_volts <= '0;
        jitter_on            <= 1'b0;
        hold_asks            <= 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight out of reset the oscillator is disabled, so both extremes must give zero.
        send_pitch(16'h7FFF);
        send_pitch(16'h8000);
        drain_samples();

        // Octave and detune at the top of the range used here, full feedback, harmonic ratio and
        // depth, and the largest base step. High pitches saturate at Nyquist here.
        apply_config(1'b1, 4, 100, 65535, 65535, 65535, 32'h7FFF_FFFF);
        send_pitch(16'h7FFF);
        send_pitch(16'h8000);
        send_pitch(16'h0000);
        send_pitch(16'h0001);
        send_pitch(16'hFFFF);
        drain_samples();

        // Octave and detune at the bottom of the range used here with a tiny base step: the increment
        // is small and rounds away to nothing at the lowest pitch, and there is no modulation.
        apply_config(1'b1, -4, -100, 0, 0, 0, 1000);
        send_pitch(16'h0000);
        send_pitch(16'h8000);
        send_pitch(16'h7FFF);
        drain_samples();

        // The same octave and detune again but with a full-size base step and moderate modulation.
        apply_config(1'b1, -4, -100, 16384, 8192, 16384, 32'h7FFF_FFFF);
        send_pitch(16'h8000);
        send_pitch(16'h7FFF);
        send_pitch(16'h0000);
        send_pitch(16'h1000);
        drain_samples();

        // Disabled with a live phase and fed-back sample: zeros out, and the state must be
        // kept intact for when the oscillator is switched back on below.
        apply_config(1'b0, 0, 0, 8192, 8192, 8192, BASE_STEP_RST);
        send_pitch(16'h1234);
        send_pitch(16'hEDCB);
        drain_samples();

        // Random phases, each with its own configuration. One early phase asks the receiver
        // for a long hold-off so that the block fills up and refuses pitch transfers, every
        // third phase runs without idling, and the final one is always free of it.
        done     = 0;
        phase_no = 0;
        volts    = '0;
        while (done < RANDOM_PITCHES) begin
            batch = $urandom_range(100, 180);
            if (RANDOM_PITCHES - done - batch < 100) begin
                batch = RANDOM_PITCHES - done;
            end
            apply_config($urandom_range(0, 7) != 0, $urandom_range(0, 8) - 4,
                         $urandom_range(0, 200) - 100, pick_gain(), pick_gain(), pick_gain(),
                         pick_base());
            jitter_on <= (done + batch < RANDOM_PITCHES) && (phase_no % 3 != 2);
            if (phase_no == 1) begin
                hold_asks <= hold_asks + 1;
            end
            for (int n = 0; n < batch; n++) begin
                volts = pick_pitch(volts);
                send_pitch(volts);
            end
            drain_samples();
            done += batch;
            phase_no++;
        end

        // Nothing is owed any more; give a stray sample time to show up before judging.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && samples_pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
